// ===== design/lwkd_pkg.sv =====
// Package for the longest window with at most k distinct values block.
// Holds the sizes, the register map and the payload types. No dependencies.
`timescale 1ns / 1ps

package lwkd_pkg;

  localparam int MAX_LEN     = 256;
  localparam int NUM_VALUES  = 256;
  localparam int VAL_W       = 8;
  localparam int OUT_W       = 9;
  localparam int MD_W        = 9;
  localparam int LEN_W       = $clog2(MAX_LEN + 1);
  localparam int HIST_AW     = $clog2(MAX_LEN);
  localparam int DIST_W      = $clog2(NUM_VALUES + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam logic REG_MAX_DISTINCT = 1'b0;
  localparam logic [MD_W-1:0] MAX_DISTINCT_RESET = MD_W'(1);

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             is_last;
  } lwkd_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] window_length;
    logic [OUT_W-1:0] longest_length;
    logic             overflow;
    logic             last_out;
  } lwkd_out_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             is_last;
    logic             ovf;
  } lwkd_job_t;

endpackage

// ===== design/longest_window_k_distinct.sv =====
// Longest window with at most max_distinct distinct byte values, per sequence.
// Per item: S_IDLE, S_INC, S_CHECK, S_HRD and S_DEC per left-edge step, then S_DONE.
// The engine takes no new item until the last is through, held by the count RAM
// read-modify-write; an item past the length limit goes from S_IDLE to S_DONE.
// Reset: synchronous rst clears queue, counts, edges and sets max_distinct to 1.
`timescale 1ns / 1ps

module longest_window_k_distinct
  import lwkd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  logic              item_valid,
  output logic              item_stall,
  input  lwkd_in_t          item,
  output logic              result_valid,
  input  logic              result_stall,
  output lwkd_out_t         result
);

  logic [MD_W-1:0] max_distinct;
  logic            job_valid;
  lwkd_job_t       job;
  logic            job_take;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_DISTINCT) ? CFG_DW'(max_distinct) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distinct <= MAX_DISTINCT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_DISTINCT) begin
      max_distinct <= pwdata[MD_W-1:0];
    end
  end

  lwkd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .job_valid  (job_valid),
    .job        (job),
    .job_take   (job_take)
  );

  lwkd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .max_distinct (max_distinct),
    .job_valid    (job_valid),
    .job          (job),
    .job_take     (job_take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== design/lwkd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module lwkd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lwkd_front.sv =====
// Front end: accepts items, tags those beyond the sequence length limit,
// and queues them for the window engine. Depends on lwkd_pkg.
`timescale 1ns / 1ps

module lwkd_front
  import lwkd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  lwkd_in_t  item,
  output logic      job_valid,
  output lwkd_job_t job,
  input  logic      job_take
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  lwkd_job_t         q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] q_count;
  logic [LEN_W-1:0]  pos;
  logic              push;
  logic              pop;
  logic              ovf;

  assign item_stall = (q_count == QCNT_W'(QUEUE_DEPTH));
  assign push       = item_valid && !item_stall;
  assign pop        = job_take && job_valid;
  assign job_valid  = (q_count != '0);
  assign job        = q_mem[rd_ptr];
  assign ovf        = (pos == LEN_W'(MAX_LEN));

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= '{value: item.value, is_last: item.is_last, ovf: ovf};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
      pos     <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
        if (item.is_last) begin
          pos <= '0;
        end else if (!ovf) begin
          pos <= pos + LEN_W'(1);
        end
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        q_count <= q_count + QCNT_W'(1);
      end else if (pop && !push) begin
        q_count <= q_count - QCNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_qcount_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    job_take |-> job_valid)
    else $error("engine took from empty queue");
`endif

endmodule

// ===== design/lwkd_back.sv =====
// Window engine: per-value counts, history, left-edge shrink loop and the
// result register. Depends on lwkd_pkg and lwkd_ram.
`timescale 1ns / 1ps

module lwkd_back
  import lwkd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [MD_W-1:0]  max_distinct,
  input  logic             job_valid,
  input  lwkd_job_t        job,
  output logic             job_take,
  output logic             result_valid,
  input  logic             result_stall,
  output lwkd_out_t        result
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_INC   = 6'b000010,
    S_CHECK = 6'b000100,
    S_HRD   = 6'b001000,
    S_DEC   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t              state, state_next;
  logic [VAL_W-1:0]    val_q;
  logic [VAL_W-1:0]    u_q;
  logic                last_q;
  logic                ovf_q;
  logic [LEN_W-1:0]    left_edge, left_edge_next;
  logic [LEN_W-1:0]    right_edge, right_edge_next;
  logic [LEN_W-1:0]    best_length, best_length_next;
  logic [DIST_W-1:0]   distinct, distinct_next;
  logic [NUM_VALUES-1:0] cnt_valid;
  logic                set_valid;
  logic                clear_seq;
  logic                out_free;
  logic [LEN_W-1:0]    win;

  logic                cnt_we;
  logic [VAL_W-1:0]    cnt_waddr;
  logic [LEN_W-1:0]    cnt_wdata;
  logic [VAL_W-1:0]    cnt_raddr;
  logic [LEN_W-1:0]    cnt_rdata;
  logic [LEN_W-1:0]    cnt_cur;
  logic [VAL_W-1:0]    cnt_addr_cur;
  logic                hist_we;
  logic [HIST_AW-1:0]  hist_raddr;
  logic [VAL_W-1:0]    hist_rdata;

  lwkd_ram #(.WIDTH(LEN_W), .DEPTH(NUM_VALUES)) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  lwkd_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_history (
    .clk   (clk),
    .we    (hist_we),
    .waddr (right_edge[HIST_AW-1:0]),
    .wdata (job.value),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  assign win          = right_edge - left_edge;
  assign out_free     = !result_valid || !result_stall;
  assign cnt_addr_cur = (state == S_INC) ? val_q : u_q;
  assign cnt_cur      = cnt_valid[cnt_addr_cur] ? cnt_rdata : '0;
  assign hist_raddr   = left_edge[HIST_AW-1:0];

  always_comb begin
    state_next       = state;
    left_edge_next   = left_edge;
    right_edge_next  = right_edge;
    best_length_next = best_length;
    distinct_next    = distinct;
    job_take         = 1'b0;
    hist_we          = 1'b0;
    cnt_we           = 1'b0;
    cnt_waddr        = cnt_addr_cur;
    cnt_wdata        = '0;
    cnt_raddr        = hist_rdata;
    set_valid        = 1'b0;
    clear_seq        = 1'b0;
    unique case (state)
      S_IDLE: begin
        cnt_raddr = job.value;
        if (job_valid) begin
          job_take   = 1'b1;
          hist_we    = !job.ovf;
          state_next = job.ovf ? S_DONE : S_INC;
        end
      end
      S_INC: begin
        cnt_we          = 1'b1;
        cnt_wdata       = cnt_cur + LEN_W'(1);
        set_valid       = 1'b1;
        right_edge_next = right_edge + LEN_W'(1);
        if (cnt_cur == '0) begin
          distinct_next = distinct + DIST_W'(1);
        end
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if ((DIST_W'(distinct) > DIST_W'(max_distinct)) && (left_edge < right_edge)) begin
          state_next = S_HRD;
        end else begin
          if (win > best_length) begin
            best_length_next = win;
          end
          state_next = S_DONE;
        end
      end
      S_HRD: begin
        state_next = S_DEC;
      end
      S_DEC: begin
        if (cnt_cur != '0) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_cur - LEN_W'(1);
          if (cnt_cur == LEN_W'(1)) begin
            distinct_next = distinct - DIST_W'(1);
          end
        end
        left_edge_next = left_edge + LEN_W'(1);
        state_next     = S_CHECK;
      end
      S_DONE: begin
        if (out_free) begin
          clear_seq  = last_q;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (clear_seq) begin
      left_edge_next   = '0;
      right_edge_next  = '0;
      best_length_next = '0;
      distinct_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && job_valid) begin
      val_q  <= job.value;
      last_q <= job.is_last;
      ovf_q  <= job.ovf;
    end
    if (state == S_HRD) begin
      u_q <= hist_rdata;
    end
    if (state == S_DONE && out_free) begin
      result.window_length  <= OUT_W'(win);
      result.longest_length <= OUT_W'(best_length);
      result.overflow       <= ovf_q;
      result.last_out       <= last_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      left_edge    <= '0;
      right_edge   <= '0;
      best_length  <= '0;
      distinct     <= '0;
      cnt_valid    <= '0;
      result_valid <= 1'b0;
    end else begin
      state       <= state_next;
      left_edge   <= left_edge_next;
      right_edge  <= right_edge_next;
      best_length <= best_length_next;
      distinct    <= distinct_next;
      if (clear_seq) begin
        cnt_valid <= '0;
      end else if (set_valid) begin
        cnt_valid[val_q] <= 1'b1;
      end
      if (state == S_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_edges_ordered: assert property (@(posedge clk) disable iff (rst)
    left_edge <= right_edge)
    else $error("left edge passed right edge");

  a_right_bound: assert property (@(posedge clk) disable iff (rst)
    right_edge <= LEN_W'(MAX_LEN))
    else $error("right edge beyond length limit");

  a_seq_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free && last_q) |=>
      (right_edge == '0 && distinct == '0 && cnt_valid == '0))
    else $error("state not cleared after last transfer");
`endif

endmodule

// ===== tb/lwkd_checker.sv =====
// Checker for longest_window_k_distinct: tracks the limit register, predicts
// each result from the accepted items and compares every result transfer.
// Depends on lwkd_pkg.
`timescale 1ns / 1ps

module lwkd_checker
  import lwkd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  input  logic              pready,
  input  logic              item_valid,
  input  logic              item_stall,
  input  lwkd_in_t          item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  lwkd_out_t         result,
  output int                errors,
  output int                pending,
  output int                overflows
);

  localparam logic [CFG_AW-1:0] LIMIT_ADDR = CFG_AW'({REG_MAX_DISTINCT, 2'b00});

  logic [MD_W-1:0]   limit;
  logic [OUT_W-1:0]  tally [NUM_VALUES];
  logic [DIST_W-1:0] distinct;
  logic [VAL_W-1:0]  trail [MAX_LEN];
  logic [LEN_W-1:0]  left_pos;
  logic [LEN_W-1:0]  right_pos;
  logic [LEN_W-1:0]  best_len;
  lwkd_out_t         expected_q [$];
  int                fails;
  int                ovf_count;
  int                result_idx;

  function automatic void clear_window();
    foreach (tally[i]) tally[i] = '0;
    distinct  = '0;
    left_pos  = '0;
    right_pos = '0;
    best_len  = '0;
  endfunction

  function automatic lwkd_out_t scan_item(lwkd_in_t it);
    lwkd_out_t r;
    logic [VAL_W-1:0] gone;
    r = '0;
    if (right_pos >= MAX_LEN) begin
      r.overflow = 1'b1;
    end else begin
      trail[right_pos[HIST_AW-1:0]] = it.value;
      if (tally[it.value] == '0) distinct++;
      tally[it.value]++;
      right_pos++;
      while (distinct > limit && left_pos < right_pos) begin
        gone = trail[left_pos[HIST_AW-1:0]];
        if (tally[gone] != '0) begin
          tally[gone]--;
          if (tally[gone] == '0) distinct--;
        end
        left_pos++;
      end
      if (right_pos - left_pos > best_len) best_len = right_pos - left_pos;
    end
    r.window_length  = OUT_W'(right_pos - left_pos);
    r.longest_length = OUT_W'(best_len);
    r.last_out       = it.is_last;
    if (it.is_last) clear_window();
    return r;
  endfunction

  task automatic report(input string what, input int want, input int got);
    fails++;
    $display("mismatch on result %0d, %s: expected %0d, got %0d",
             result_idx, what, want, got);
  endtask

  always @(posedge clk) begin
    lwkd_out_t want;
    if (rst) begin
      limit = MAX_DISTINCT_RESET;
      clear_window();
      expected_q.delete();
      fails = 0;
      ovf_count = 0;
      result_idx = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
        limit = pwdata[MD_W-1:0];
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          report("transfer with nothing pending", 0, 1);
        end else begin
          want = expected_q.pop_front();
          if (result.window_length != want.window_length)
            report("window_length", want.window_length, result.window_length);
          if (result.longest_length != want.longest_length)
            report("longest_length", want.longest_length, result.longest_length);
          if (result.overflow != want.overflow)
            report("overflow", want.overflow, result.overflow);
          if (result.last_out != want.last_out)
            report("last_out", want.last_out, result.last_out);
          if (want.overflow) ovf_count++;
        end
        result_idx++;
      end
      if (item_valid && !item_stall)
        expected_q.push_back(scan_item(item));
    end
    errors    <= fails;
    pending   <= expected_q.size();
    overflows <= ovf_count;
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the longest_window_k_distinct testbench: clock, reset, limit register
// writes, item stimulus, result stall pattern and the verdict.
// Depends on lwkd_pkg, the block itself and lwkd_checker.
`timescale 1ns / 1ps

module testbench;
  import lwkd_pkg::*;

  localparam logic [CFG_AW-1:0] LIMIT_ADDR = CFG_AW'({REG_MAX_DISTINCT, 2'b00});
  localparam int CYCLE_LIMIT = 800000;
  localparam int PHASE_ITEMS = 130;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  logic              item_valid;
  logic              item_stall;
  lwkd_in_t          item;
  logic              result_valid;
  logic              result_stall;
  lwkd_out_t         result;

  int errors;
  int pending;
  int overflows;
  int cycles;
  int items_sent;
  int seqs_sent;
  int settings_used;
  int phase_items;
  bit hold_req;
  bit calm;

  longest_window_k_distinct dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .item_valid, .item_stall, .item, .result_valid, .result_stall, .result
  );

  lwkd_checker u_checker (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .item_valid, .item_stall, .item, .result_valid, .result_stall, .result,
    .errors, .pending, .overflows
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycles, pending);
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: short stalls, some long ones, one long hold-off on request
  initial begin
    int r;
    result_stall = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else if (calm) begin
        result_stall <= 1'b0;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 9);
        if (r < 4) begin
          result_stall <= 1'b0;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (r < 8) begin
          result_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else if (r < 9) begin
          result_stall <= 1'b1;
          repeat ($urandom_range(5, 15)) @(posedge clk);
        end else begin
          result_stall <= 1'b1;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end
      end
    end
  end

  task automatic write_limit(input logic [MD_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= CFG_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // the pending count is registered in the checker and trails the last transfer
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_item(input logic [VAL_W-1:0] v, input logic last);
    int gap;
    lwkd_in_t it;
    gap = pick_gap();
    it.value   = v;
    it.is_last = last;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    items_sent++;
    phase_items++;
    if (last) seqs_sent++;
  endtask

  // narrow alphabets and runs make windows grow and shrink; full range covers all bits
  task automatic send_sequence(input int len);
    int style;
    int span;
    logic [VAL_W-1:0] base;
    logic [VAL_W-1:0] v;
    style = $urandom_range(0, 3);
    span  = $urandom_range(1, 6);
    base  = VAL_W'($urandom_range(0, 255));
    v     = base;
    for (int i = 0; i < len; i++) begin
      case (style)
        0, 1: begin
          v = base + VAL_W'($urandom_range(0, span - 1));
        end
        2: begin
          if ($urandom_range(0, 3) == 0) v = base + VAL_W'($urandom_range(0, span - 1));
        end
        default: begin
          v = VAL_W'($urandom_range(0, 255));
        end
      endcase
      send_item(v, i == len - 1);
    end
  endtask

  task automatic send_list(input logic [VAL_W-1:0] vals [$]);
    foreach (vals[i]) send_item(vals[i], i == vals.size() - 1);
  endtask

  initial begin
    logic [MD_W-1:0] settings [9];
    int r;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    item_valid   = 1'b0;
    item         = '0;
    hold_req     = 1'b0;
    calm         = 1'b0;
    items_sent   = 0;
    seqs_sent    = 0;
    settings_used = 0;
    phase_items  = 0;
    settings = '{9'd1, 9'd0, 9'd2, 9'd3, 9'd8, 9'd256, 9'd257, 9'd511, 9'd5};
    settings[8] = MD_W'($urandom_range(4, 40));
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_limit(MD_W'(2));
    send_list('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'h01, 8'h02});
    send_list('{8'h80});
    send_list('{8'hFF, 8'hFF, 8'hFF, 8'h00});
    send_list('{8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h55});
    send_list('{8'h07, 8'h07, 8'h08, 8'h07, 8'h09, 8'h09});

    foreach (settings[p]) begin
      drain();
      write_limit(settings[p]);
      phase_items = 0;
      calm = (p == 4);
      if (p == 3) hold_req = 1'b1;
      // full-length sequences past the cap, one per wide setting
      if (p >= 5 && p <= 7) send_sequence(MAX_LEN + $urandom_range(1, 20));
      while (phase_items < PHASE_ITEMS) begin
        r = $urandom_range(0, 39);
        if (r == 0) send_sequence($urandom_range(MAX_LEN - 4, MAX_LEN + 30));
        else send_sequence($urandom_range(1, 24));
      end
    end
    calm = 1'b0;
    drain();

    $display("covered %0d items in %0d sequences over %0d limit settings",
             items_sent, seqs_sent, settings_used);
    $display("%0d results past the length cap, %0d mismatches", overflows, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
